[hw/rtl/sft_pkg.sv]
package sft_pkg;

   localparam int NODE_COUNT = 5;
   localparam int NODE_IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam logic [7:0] NODE_COUNT_ID = 8'(NODE_COUNT);

   localparam int TIME_W    = 32;
   localparam int TIMEOUT_W = 20;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30000);

   localparam logic [1:0] FUNC_FRAME = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHECK = 2'd1;
   localparam logic [1:0] STATUS_BAD_ID    = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         node_id;
      logic signed [15:0] temperature;
      logic [15:0]        battery_mv;
      logic [15:0]        seq_num;
      logic [7:0]         check_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         node_number;
      logic signed [15:0] node_temperature;
      logic [15:0]        node_voltage;
      logic [15:0]        node_seq;
      logic [15:0]        lost_frames;
      logic               is_online;
      logic               timed_out;
   } rsp_item_type;

endpackage

[hw/rtl/sft_node_table.sv]
module sft_node_table
   import sft_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  req_item_type         item,
   input  logic                 fire,
   input  logic [TIMEOUT_W-1:0] timeout_ms,
   output rsp_item_type         result,
   output logic                 has_result
);

   logic [TIME_W-1:0]      now_ff, now_in;
   logic [TIME_W-1:0]      last_heard_ff [NODE_COUNT];
   logic [TIME_W-1:0]      last_heard_in [NODE_COUNT];
   logic [15:0]            last_seq_ff [NODE_COUNT];
   logic [15:0]            last_seq_in [NODE_COUNT];
   logic [15:0]            lost_ff [NODE_COUNT];
   logic [15:0]            lost_in [NODE_COUNT];
   logic                   online_ff [NODE_COUNT];
   logic                   online_in [NODE_COUNT];
   logic signed [15:0]     temp_ff [NODE_COUNT];
   logic signed [15:0]     temp_in [NODE_COUNT];
   logic [15:0]            volt_ff [NODE_COUNT];
   logic [15:0]            volt_in [NODE_COUNT];

   logic [7:0]             xor_sum;
   logic                   check_ok;
   logic                   id_ok;
   logic [7:0]             id_less_one;
   logic [NODE_IDX_W-1:0]  idx;
   logic [TIME_W-1:0]      now_next;
   logic [TIME_W-1:0]      timeout_ext;
   logic                   seq_gap;
   logic [15:0]            lost_next;

   assign xor_sum = item.node_id ^ item.temperature[7:0] ^ item.temperature[15:8]
                  ^ item.battery_mv[7:0] ^ item.battery_mv[15:8]
                  ^ item.seq_num[7:0] ^ item.seq_num[15:8];
   assign check_ok    = (xor_sum == item.check_byte);
   assign id_ok       = (item.node_id != 8'd0) && (item.node_id <= NODE_COUNT_ID);
   assign id_less_one = item.node_id - 8'd1;
   assign idx         = id_less_one[NODE_IDX_W-1:0];
   assign now_next    = now_ff + TIME_W'(1);
   assign timeout_ext = TIME_W'(timeout_ms);

   // a stored sequence of zero means nothing heard yet: no gap counted
   assign seq_gap   = (last_seq_ff[idx] != 16'd0) &&
                      ({1'b0, item.seq_num} > ({1'b0, last_seq_ff[idx]} + 17'd1));
   assign lost_next = seq_gap ? (lost_ff[idx] + item.seq_num - last_seq_ff[idx] - 16'd1)
                              : lost_ff[idx];

   always_comb begin
      now_in        = now_ff;
      last_heard_in = last_heard_ff;
      last_seq_in   = last_seq_ff;
      lost_in       = lost_ff;
      online_in     = online_ff;
      temp_in       = temp_ff;
      volt_in       = volt_ff;
      result             = '0;
      result.node_number = item.node_id;
      has_result         = 1'b1;

      unique case (item.func)
         FUNC_FRAME: begin
            priority if (!check_ok) begin
               result.status = STATUS_BAD_CHECK;
            end else if (!id_ok) begin
               result.status = STATUS_BAD_ID;
            end else begin
               result.node_temperature = item.temperature;
               result.node_voltage     = item.battery_mv;
               result.node_seq         = item.seq_num;
               result.lost_frames      = lost_next;
               result.is_online        = 1'b1;
               // stamped with the current time, so silence is zero
               result.timed_out        = 1'b0;
               if (fire) begin
                  temp_in[idx]       = item.temperature;
                  volt_in[idx]       = item.battery_mv;
                  last_heard_in[idx] = now_ff;
                  online_in[idx]     = 1'b1;
                  lost_in[idx]       = lost_next;
                  last_seq_in[idx]   = item.seq_num;
               end
            end
         end
         FUNC_TICK: begin
            result.node_number = 8'd0;
            if (fire) begin
               now_in = now_next;
               for (int k = 0; k < NODE_COUNT; k++) begin
                  if (online_ff[k] && ((now_next - last_heard_ff[k]) > timeout_ext)) begin
                     online_in[k] = 1'b0;
                  end
               end
            end
         end
         FUNC_READ: begin
            if (!id_ok) begin
               result.status = STATUS_BAD_ID;
            end else begin
               result.node_temperature = temp_ff[idx];
               result.node_voltage     = volt_ff[idx];
               result.node_seq         = last_seq_ff[idx];
               result.lost_frames      = lost_ff[idx];
               result.is_online        = online_ff[idx];
               result.timed_out        = (now_ff - last_heard_ff[idx]) > timeout_ext;
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
         for (int k = 0; k < NODE_COUNT; k++) begin
            last_heard_ff[k] <= '0;
            last_seq_ff[k]   <= '0;
            lost_ff[k]       <= '0;
            online_ff[k]     <= 1'b0;
            temp_ff[k]       <= '0;
            volt_ff[k]       <= '0;
         end
      end else begin
         now_ff        <= now_in;
         last_heard_ff <= last_heard_in;
         last_seq_ff   <= last_seq_in;
         lost_ff       <= lost_in;
         online_ff     <= online_in;
         temp_ff       <= temp_in;
         volt_ff       <= volt_in;
      end
   end

endmodule

[hw/rtl/sensor_frame_tracker.sv]
// Sensor frame tracker: per-node bookkeeping at the sink end of a sensor link.
// Request channel (req_valid / req_stall): func selects a received frame, a
// one millisecond tick or a read of one node's record. Every request but the
// unused func code returns exactly one response on the rsp_ channel
// (rsp_valid / rsp_stall); the unused code is dropped without a response.
// A request taken into the input register passes through the node table and
// its response is registered in the result register, which drives rsp_.
// Throughput: one request per cycle unless rsp_stall backs up; the node table
// update and all timeout compares lie between the input and result registers.
// When rsp_stall is held the result register keeps its response, the input
// register fills behind it and then req_stall rises; no request is lost.
// csr_ writes timeout_ms (always ready); write it only while the block is idle.
// Reset (synchronous) clears the millisecond counter and every node record,
// empties both registers and restores timeout_ms to 30000.
module sensor_frame_tracker
   import sft_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [7:0]           req_node_id,
   input  logic signed [15:0]   req_temperature,
   input  logic [15:0]          req_battery_mv,
   input  logic [15:0]          req_seq_num,
   input  logic [7:0]           req_check_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [7:0]           rsp_node_number,
   output logic signed [15:0]   rsp_node_temperature,
   output logic [15:0]          rsp_node_voltage,
   output logic [15:0]          rsp_node_seq,
   output logic [15:0]          rsp_lost_frames,
   output logic                 rsp_is_online,
   output logic                 rsp_timed_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [TIMEOUT_W-1:0] csr_data
);

   logic                 in_valid_ff, in_valid_in;
   req_item_type         in_item_ff, in_item_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_item_type         out_item_ff, out_item_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;

   rsp_item_type         table_result;
   logic                 table_has_result;
   logic                 in_fire;

   sft_node_table u_table (
      .clock      (clock),
      .reset      (reset),
      .item       (in_item_ff),
      .fire       (in_fire),
      .timeout_ms (timeout_ff),
      .result     (table_result),
      .has_result (table_has_result)
   );

   // a request with no response can leave even while the result register is held
   assign in_fire   = in_valid_ff && (!out_valid_ff || !rsp_stall || !table_has_result);
   assign req_stall = in_valid_ff && !in_fire;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_item_in  = '{func:        req_func,
                         node_id:     req_node_id,
                         temperature: req_temperature,
                         battery_mv:  req_battery_mv,
                         seq_num:     req_seq_num,
                         check_byte:  req_check_byte};
      end

      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (in_fire && table_has_result) begin
         out_valid_in = 1'b1;
         out_item_in  = table_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end

      timeout_in = timeout_ff;
      if (csr_valid && csr_ready) begin
         timeout_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         timeout_ff   <= timeout_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_item_ff.status;
   assign rsp_node_number      = out_item_ff.node_number;
   assign rsp_node_temperature = out_item_ff.node_temperature;
   assign rsp_node_voltage     = out_item_ff.node_voltage;
   assign rsp_node_seq         = out_item_ff.node_seq;
   assign rsp_lost_frames      = out_item_ff.lost_frames;
   assign rsp_is_online        = out_item_ff.is_online;
   assign rsp_timed_out        = out_item_ff.timed_out;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import sft_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 80;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_func = FUNC_TICK;
   logic [7:0]           req_node_id = '0;
   logic signed [15:0]   req_temperature = '0;
   logic [15:0]          req_battery_mv = '0;
   logic [15:0]          req_seq_num = '0;
   logic [7:0]           req_check_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [7:0]           rsp_node_number;
   logic signed [15:0]   rsp_node_temperature;
   logic [15:0]          rsp_node_voltage;
   logic [15:0]          rsp_node_seq;
   logic [15:0]          rsp_lost_frames;
   logic                 rsp_is_online;
   logic                 rsp_timed_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [TIMEOUT_W-1:0] csr_data = '0;

   sensor_frame_tracker DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_node_id          (req_node_id),
      .req_temperature      (req_temperature),
      .req_battery_mv       (req_battery_mv),
      .req_seq_num          (req_seq_num),
      .req_check_byte       (req_check_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_node_number      (rsp_node_number),
      .rsp_node_temperature (rsp_node_temperature),
      .rsp_node_voltage     (rsp_node_voltage),
      .rsp_node_seq         (rsp_node_seq),
      .rsp_lost_frames      (rsp_lost_frames),
      .rsp_is_online        (rsp_is_online),
      .rsp_timed_out        (rsp_timed_out),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // shadow of the node table
   logic [TIMEOUT_W-1:0] timeout_setting;
   logic [31:0]          clock_ms;
   logic [31:0]          heard_at   [NODE_COUNT];
   logic [15:0]          seq_last   [NODE_COUNT];
   logic [15:0]          lost_tally [NODE_COUNT];
   logic                 online     [NODE_COUNT];
   logic signed [15:0]   temp_last  [NODE_COUNT];
   logic [15:0]          volt_last  [NODE_COUNT];

   // sequence numbers used when generating frames, per node
   logic [15:0]          seq_cursor [NODE_COUNT] = '{default: 16'h0000};

   req_item_type request_backlog [$];
   rsp_item_type expected_records [$];

   int requests_queued   = 0;
   int requests_sent     = 0;
   int requests_accepted = 0;
   int responses_seen    = 0;
   int error_count       = 0;
   int settings_used     = 1;

   req_item_type cur_req;
   rsp_item_type next_record;
   rsp_item_type want_record;
   bit           produces;
   bit           keep_offer;
   int           send_gap  = 0;
   int           recv_wait = 0;
   int           hold_left = 0;

   int unsigned  timeout_plan [5] = '{0, 5, 1000000, 2, 17};

   task automatic report_mismatch(string msg);
      $display("ERROR t=%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic compare_field(string name, longint got, longint want);
      if (got != want)
         report_mismatch($sformatf("response %0d: %s is %0d, expected %0d",
                                   responses_seen, name, got, want));
   endtask

   function automatic logic [7:0] frame_check(logic [7:0] id, logic [15:0] t,
                                              logic [15:0] v, logic [15:0] s);
      return id ^ t[7:0] ^ t[15:8] ^ v[7:0] ^ v[15:8] ^ s[7:0] ^ s[15:8];
   endfunction

   function automatic logic silent_past_timeout(int k);
      logic [31:0] silence;
      silence = clock_ms - heard_at[k];
      return silence > 32'(timeout_setting);
   endfunction

   function automatic rsp_item_type node_record(int k, logic [7:0] id);
      rsp_item_type rec;
      rec.status           = STATUS_OK;
      rec.node_number      = id;
      rec.node_temperature = temp_last[k];
      rec.node_voltage     = volt_last[k];
      rec.node_seq         = seq_last[k];
      rec.lost_frames      = lost_tally[k];
      rec.is_online        = online[k];
      rec.timed_out        = silent_past_timeout(k);
      return rec;
   endfunction

   function automatic rsp_item_type error_record(logic [1:0] code, logic [7:0] id);
      rsp_item_type rec;
      rec             = '0;
      rec.status      = code;
      rec.node_number = id;
      return rec;
   endfunction

   function automatic void tracker_update(input req_item_type r, output rsp_item_type res,
                                          output bit has_rsp);
      int  k;
      logic in_range;
      in_range = (r.node_id >= 8'd1) && (r.node_id <= NODE_COUNT_ID);
      k        = int'(r.node_id) - 1;
      has_rsp  = 1'b1;
      res      = '0;
      case (r.func)
         FUNC_FRAME: begin
            if (frame_check(r.node_id, r.temperature, r.battery_mv, r.seq_num)
                != r.check_byte) begin
               res = error_record(STATUS_BAD_CHECK, r.node_id);
            end else if (!in_range) begin
               res = error_record(STATUS_BAD_ID, r.node_id);
            end else begin
               temp_last[k] = r.temperature;
               volt_last[k] = r.battery_mv;
               heard_at[k]  = clock_ms;
               online[k]    = 1'b1;
               if (seq_last[k] != 16'd0 && {1'b0, r.seq_num} > {1'b0, seq_last[k]} + 17'd1)
                  lost_tally[k] = lost_tally[k] + (r.seq_num - seq_last[k] - 16'd1);
               seq_last[k] = r.seq_num;
               res = node_record(k, r.node_id);
            end
         end
         FUNC_TICK: begin
            clock_ms = clock_ms + 32'd1;
            for (int n = 0; n < NODE_COUNT; n++)
               if (online[n] && silent_past_timeout(n))
                  online[n] = 1'b0;
         end
         FUNC_READ: begin
            if (!in_range)
               res = error_record(STATUS_BAD_ID, r.node_id);
            else
               res = node_record(k, r.node_id);
         end
         default: has_rsp = 1'b0;
      endcase
   endfunction

   function automatic req_item_type good_frame(logic [7:0] id, logic [15:0] t,
                                               logic [15:0] v, logic [15:0] s);
      req_item_type r;
      r.func        = FUNC_FRAME;
      r.node_id     = id;
      r.temperature = t;
      r.battery_mv  = v;
      r.seq_num     = s;
      r.check_byte  = frame_check(id, t, v, s);
      return r;
   endfunction

   function automatic req_item_type plain_request(logic [1:0] func, logic [7:0] id);
      req_item_type r;
      r.func        = func;
      r.node_id     = id;
      r.temperature = 16'($urandom);
      r.battery_mv  = 16'($urandom);
      r.seq_num     = 16'($urandom);
      r.check_byte  = 8'($urandom);
      return r;
   endfunction

   function automatic req_item_type random_request();
      req_item_type r;
      int           pick;
      int           node;
      logic [15:0]  seq;
      pick = $urandom_range(0, 99);
      r    = plain_request(FUNC_TICK, 8'($urandom));
      if (pick < 45) begin
         // well-formed frame, sequence mostly creeping forward
         node = $urandom_range(1, NODE_COUNT);
         case ($urandom_range(0, 9))
            6:       seq = 16'($urandom);
            7:       seq = 16'hFFFF;
            8:       seq = 16'h0000;
            9:       seq = seq_cursor[node-1] - 16'($urandom_range(1, 5));
            default: seq = seq_cursor[node-1] + 16'($urandom_range(0, 3));
         endcase
         seq_cursor[node-1] = seq;
         r = good_frame(8'(node), r.temperature, r.battery_mv, seq);
      end else if (pick < 55) begin
         r.func = FUNC_FRAME;
         if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 1))
               r.node_id = 8'($urandom_range(1, NODE_COUNT));
            r.check_byte = frame_check(r.node_id, r.temperature, r.battery_mv, r.seq_num)
                           ^ 8'($urandom_range(1, 255));
         end else begin
            r.node_id = ($urandom_range(0, 3) == 0) ? 8'h00
                        : 8'($urandom_range(NODE_COUNT + 1, 255));
            r.check_byte = frame_check(r.node_id, r.temperature, r.battery_mv, r.seq_num);
         end
      end else if (pick < 80) begin
         r.func = FUNC_TICK;
      end else if (pick < 95) begin
         r.func = FUNC_READ;
         if ($urandom_range(0, 3) != 0)
            r.node_id = 8'($urandom_range(1, NODE_COUNT));
      end else begin
         r.func = FUNC_UNUSED;
      end
      return r;
   endfunction

   task automatic queue_request(req_item_type r);
      request_backlog.push_back(r);
      requests_queued++;
   endtask

   // everything sent has been accepted and answered; allow for a dropped request
   task automatic wait_for_drain();
      do @(posedge clock);
      while (requests_accepted != requests_queued || expected_records.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      timeout_setting = value;
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         timeout_setting = TIMEOUT_RESET;
         clock_ms = '0;
         for (int k = 0; k < NODE_COUNT; k++) begin
            heard_at[k]   = '0;
            seq_last[k]   = '0;
            lost_tally[k] = '0;
            online[k]     = 1'b0;
            temp_last[k]  = '0;
            volt_last[k]  = '0;
         end
      end else begin
         keep_offer = req_valid;
         if (req_valid && !req_stall) begin
            tracker_update(cur_req, next_record, produces);
            if (produces)
               expected_records.push_back(next_record);
            requests_accepted++;
            keep_offer = 1'b0;
         end
         if (!keep_offer) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               cur_req = request_backlog.pop_front();
               req_func        <= cur_req.func;
               req_node_id     <= cur_req.node_id;
               req_temperature <= cur_req.temperature;
               req_battery_mv  <= cur_req.battery_mv;
               req_seq_num     <= cur_req.seq_num;
               req_check_byte  <= cur_req.check_byte;
               req_valid       <= 1'b1;
               requests_sent++;
               send_gap = (((requests_sent / 40) % 3) == 1) ? 0 : $urandom_range(0, 15);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_records.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                         responses_seen));
            end else begin
               want_record = expected_records.pop_front();
               compare_field("status",      rsp_status,           want_record.status);
               compare_field("node_number", rsp_node_number,      want_record.node_number);
               compare_field("temperature", rsp_node_temperature, want_record.node_temperature);
               compare_field("voltage",     rsp_node_voltage,     want_record.node_voltage);
               compare_field("seq",         rsp_node_seq,         want_record.node_seq);
               compare_field("lost_frames", rsp_lost_frames,      want_record.lost_frames);
               compare_field("is_online",   rsp_is_online,        want_record.is_online);
               compare_field("timed_out",   rsp_timed_out,        want_record.timed_out);
            end
            responses_seen++;
            recv_wait = (((responses_seen / 30) % 3) == 2) ? 0 : $urandom_range(0, 15);
            // one long hold so the block backs up into req_stall
            if (responses_seen == HOLD_AT)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

   initial begin : stimulus
      req_item_type odd_req;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset timeout
      queue_request(plain_request(FUNC_READ, 8'd0));
      queue_request(plain_request(FUNC_READ, 8'd1));
      queue_request(plain_request(FUNC_TICK, 8'd0));
      queue_request(good_frame(8'd1, 16'h8000, 16'hFFFF, 16'd0));
      queue_request(good_frame(8'd1, 16'h7FFF, 16'h0000, 16'd100));  // old seq zero: no gap
      queue_request(good_frame(NODE_COUNT_ID, 16'd0, 16'd1234, 16'd10));
      queue_request(good_frame(NODE_COUNT_ID, 16'hFFFF, 16'd4321, 16'd15));
      queue_request(good_frame(NODE_COUNT_ID, 16'd5, 16'd3000, 16'd16));
      queue_request(good_frame(NODE_COUNT_ID, 16'd6, 16'd3001, 16'd16));
      queue_request(good_frame(NODE_COUNT_ID, 16'd7, 16'd3002, 16'd3));
      // lost counter wraps past 65535
      queue_request(good_frame(8'd3, 16'd100, 16'd3300, 16'd1));
      queue_request(good_frame(8'd3, 16'd101, 16'd3301, 16'hFFFF));
      queue_request(good_frame(8'd3, 16'd102, 16'd3302, 16'd1));
      queue_request(good_frame(8'd3, 16'd103, 16'd3303, 16'hFFFF));
      queue_request(good_frame(8'd3, 16'd104, 16'd3304, 16'hFFFF));
      // bad check byte, also with an id that is out of range
      odd_req = good_frame(8'd2, 16'd42, 16'd3300, 16'd7);
      odd_req.check_byte ^= 8'h5A;
      queue_request(odd_req);
      odd_req = good_frame(8'd0, 16'd42, 16'd3300, 16'd7);
      odd_req.check_byte ^= 8'h01;
      queue_request(odd_req);
      queue_request(good_frame(8'd0, 16'd1, 16'd2, 16'd3));
      queue_request(good_frame(NODE_COUNT_ID + 8'd1, 16'd1, 16'd2, 16'd3));
      queue_request(good_frame(8'hFF, 16'd1, 16'd2, 16'd3));
      queue_request(plain_request(FUNC_READ, 8'hFF));
      queue_request(plain_request(FUNC_READ, NODE_COUNT_ID + 8'd1));
      queue_request(plain_request(FUNC_TICK, 8'hFF));
      queue_request(plain_request(FUNC_UNUSED, 8'd1));
      queue_request(plain_request(FUNC_READ, NODE_COUNT_ID));
      queue_request(plain_request(FUNC_READ, 8'd3));
      wait_for_drain();

      foreach (timeout_plan[p]) begin
         write_timeout(TIMEOUT_W'(timeout_plan[p]));
         repeat (PHASE_ITEMS) queue_request(random_request());
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      $display("ran %0d requests, %0d responses checked, %0d mismatches",
               requests_accepted, responses_seen, error_count);
      $display("covered %0d timeout settings from 0 to 1000000, a long response hold",
               settings_used);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
